// ===== src/ust_pkg.sv =====
// shared constants, operation codes and result type for the unordered set table
package ust_pkg;

    localparam int DEF_DEPTH       = 64;
    localparam int DEF_VALUE_WIDTH = 32;

    localparam int MODE_W  = 2;
    localparam int VALUE_W = 32;
    localparam int SLOT_W  = 7;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-1:0] count;
        logic              full_refused;
    } res_t;

endpackage

// ===== src/unordered_set_table.sv =====
// An item is accepted when start is high while busy is low. The store has a single
// read port and is scanned one slot per cycle. For each item the held entries are read
// in turn until a match (none when the table is empty), the registered read data is
// compared, the outcome is acted on, and a remove that finds its value then moves the
// last entry down into the hole. The result appears on the output ports for
// exactly one cycle with done high and cannot be held off; busy falls in that same cycle,
// so the next item may be started while the result is shown.
module unordered_set_table #(
    parameter int DEPTH       = ust_pkg::DEF_DEPTH,
    parameter int VALUE_WIDTH = ust_pkg::DEF_VALUE_WIDTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [ust_pkg::MODE_W-1:0]  mode,
    input  logic [ust_pkg::VALUE_W-1:0] value,
    output logic                        done,
    output logic                        found,
    output logic [ust_pkg::SLOT_W-1:0]  slot,
    output logic [ust_pkg::SLOT_W-1:0]  count,
    output logic                        full_refused
);
    import ust_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic [VALUE_WIDTH-1:0] rd_data;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [VALUE_WIDTH-1:0] wr_data;
    logic                   fin;
    res_t                   res;

    logic done_reg;
    res_t res_reg;

    ust_ctrl #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH),
        .AW          (AW),
        .CW          (CW)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .mode    (mode),
        .value   (value),
        .busy    (busy),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .fin     (fin),
        .res     (res)
    );

    ust_mem #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH),
        .AW          (AW)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // result beat held in registers so the next item can start underneath it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= fin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin)
        begin
            res_reg <= res;
        end
    end

    assign done         = done_reg;
    assign found        = res_reg.found;
    assign slot         = res_reg.slot;
    assign count        = res_reg.count;
    assign full_refused = res_reg.full_refused;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not make the block busy");

    a_fin_busy: assert property (@(posedge clk) disable iff (!rst_n)
        fin |-> busy)
        else $error("result produced while idle");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result beat lasted more than one cycle");

    a_refuse_miss: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(full_refused && found))
        else $error("refused insert of a value already held");

endmodule

// ===== src/ust_mem.sv =====
// entry store: one write port, one read port with registered read data
module ust_mem #(
    parameter int DEPTH       = ust_pkg::DEF_DEPTH,
    parameter int VALUE_WIDTH = ust_pkg::DEF_VALUE_WIDTH,
    parameter int AW          = 6
) (
    input  logic                   clk,
    input  logic                   rd_en,
    input  logic [AW-1:0]          rd_addr,
    output logic [VALUE_WIDTH-1:0] rd_data,
    input  logic                   wr_en,
    input  logic [AW-1:0]          wr_addr,
    input  logic [VALUE_WIDTH-1:0] wr_data
);
    import ust_pkg::*;

    logic [VALUE_WIDTH-1:0] entry_mem [DEPTH];
    logic [VALUE_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= entry_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/ust_ctrl.sv =====
// sequencer: scans the store, then appends, moves the last entry down, or reports
module ust_ctrl #(
    parameter int DEPTH       = ust_pkg::DEF_DEPTH,
    parameter int VALUE_WIDTH = ust_pkg::DEF_VALUE_WIDTH,
    parameter int AW          = 6,
    parameter int CW          = 7
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [ust_pkg::MODE_W-1:0]  mode,
    input  logic [ust_pkg::VALUE_W-1:0] value,
    output logic                       busy,
    output logic                       rd_en,
    output logic [AW-1:0]              rd_addr,
    input  logic [VALUE_WIDTH-1:0]     rd_data,
    output logic                       wr_en,
    output logic [AW-1:0]              wr_addr,
    output logic [VALUE_WIDTH-1:0]     wr_data,
    output logic                       fin,
    output ust_pkg::res_t              res
);
    import ust_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_ACT  = 2'd2;
    localparam logic [1:0] S_WB   = 2'd3;

    logic [1:0]             state_reg,   state_next;
    logic [MODE_W-1:0]      mode_reg,    mode_next;
    logic [VALUE_WIDTH-1:0] key_reg,     key_next;
    logic [CW-1:0]          count_reg,   count_next;
    logic [CW-1:0]          before_reg,  before_next;
    logic [CW-1:0]          pos_reg,     pos_next;
    logic                   hit_reg,     hit_next;
    logic [CW-1:0]          issue_reg,   issue_next;
    logic [CW-1:0]          chk_idx_reg, chk_idx_next;
    logic                   chk_vld_reg, chk_vld_next;

    logic          issue_more;
    logic [CW-1:0] last_idx;
    logic          refused;

    assign issue_more = issue_reg < before_reg;
    assign last_idx   = CW'(before_reg - 1'b1);
    assign busy       = state_reg != S_IDLE;

    always_comb
    begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        key_next     = key_reg;
        count_next   = count_reg;
        before_next  = before_reg;
        pos_next     = pos_reg;
        hit_next     = hit_reg;
        issue_next   = issue_reg;
        chk_idx_next = chk_idx_reg;
        chk_vld_next = chk_vld_reg;
        rd_en        = 1'b0;
        rd_addr      = issue_reg[AW-1:0];
        wr_en        = 1'b0;
        wr_addr      = before_reg[AW-1:0];
        wr_data      = key_reg;
        fin          = 1'b0;
        refused      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    mode_next    = mode;
                    key_next     = VALUE_WIDTH'(value);
                    before_next  = count_reg;
                    pos_next     = count_reg;
                    hit_next     = 1'b0;
                    issue_next   = '0;
                    chk_vld_next = 1'b0;
                    state_next   = (count_reg == '0) ? S_ACT : S_SCAN;
                end
            end
            S_SCAN:
            begin
                // one read issued per cycle, compare on the data coming back
                rd_en        = issue_more;
                chk_vld_next = issue_more;
                chk_idx_next = issue_reg;
                if (issue_more)
                begin
                    issue_next = CW'(issue_reg + 1'b1);
                end
                if (chk_vld_reg)
                begin
                    if (rd_data == key_reg)
                    begin
                        hit_next     = 1'b1;
                        pos_next     = chk_idx_reg;
                        chk_vld_next = 1'b0;
                        state_next   = S_ACT;
                    end
                    else if (chk_idx_reg == last_idx)
                    begin
                        chk_vld_next = 1'b0;
                        state_next   = S_ACT;
                    end
                end
            end
            S_ACT:
            begin
                unique case (mode_reg)
                    MODE_INSERT:
                    begin
                        if (!hit_reg)
                        begin
                            if (before_reg == CW'(DEPTH))
                            begin
                                refused = 1'b1;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = CW'(before_reg + 1'b1);
                            end
                        end
                        fin        = 1'b1;
                        state_next = S_IDLE;
                    end
                    MODE_REMOVE:
                    begin
                        if (hit_reg)
                        begin
                            // fetch the last entry to fill the hole
                            rd_en      = 1'b1;
                            rd_addr    = last_idx[AW-1:0];
                            state_next = S_WB;
                        end
                        else
                        begin
                            fin        = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    default:
                    begin
                        fin        = 1'b1;
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_WB:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg[AW-1:0];
                wr_data    = rd_data;
                count_next = last_idx;
                fin        = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.found        = hit_reg;
        res.slot         = SLOT_W'(pos_reg);
        res.count        = SLOT_W'(count_next);
        res.full_refused = refused;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            chk_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            chk_vld_reg <= chk_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg    <= mode_next;
        key_reg     <= key_next;
        before_reg  <= before_next;
        pos_reg     <= pos_next;
        hit_reg     <= hit_next;
        issue_reg   <= issue_next;
        chk_idx_reg <= chk_idx_next;
    end

endmodule
